// ===== rtl/lph_pkg.sv =====
// Shared types and constants for the linear-probing hash map.
// Used by every module of the block but lph_queue; depends on nothing.
package lph_pkg;

	localparam int SLOTS_DEF      = 1024;
	localparam int VALUE_BITS_DEF = 32;
	localparam int KEY_BITS       = 64;
	localparam int WORD_BITS      = 32;
	localparam int COUNT_BITS     = 11;
	localparam int STATUS_BITS    = 3;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [STATUS_BITS-1:0] ST_NEW     = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_UPDATED = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_HIT     = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_MISS    = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd4;

	localparam logic [63:0] HASH_ADD  = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] HASH_MUL1 = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] HASH_MUL2 = 64'h94D0_49BB_1331_11EB;

	typedef struct packed {
		logic [1:0]           mode;
		logic [KEY_BITS-1:0]  key;
		logic [WORD_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [WORD_BITS-1:0]   value;
		logic [COUNT_BITS-1:0]  count;
	} rsp_t;

endpackage

// ===== rtl/lph_front.sv =====
// Front end: accepts requests and computes the home slot of each key.
// Uses lph_pkg; a 32x32 multiplier for the mix and a reciprocal remainder unit.
module lph_front #(
	parameter int SLOTS = lph_pkg::SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lph_pkg::req_t        in_req,
	output logic                 push,
	input  logic                 full,
	output lph_pkg::req_t        item_req,
	output logic [$clog2(SLOTS)-1:0] item_home
);
	localparam int IW = $clog2(SLOTS);
	localparam logic [32:0] SLOTS_L = 33'(SLOTS);
	localparam logic [31:0] RCP     = 32'(64'h1_0000_0000 / 64'(SLOTS));

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_MUL  = 2'd1;
	localparam logic [1:0] F_MOD  = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;

	logic [1:0]    st_q;
	lph_pkg::req_t req_q;
	logic [63:0]   x_q, acc_q, h_q;
	logic [1:0]    ph_q;
	logic          mul_q;
	logic [2:0]    cnt_q;
	logic [IW-1:0] rem_q;
	logic [15:0]   qe_q;

	logic [63:0] z, mb, prod, nacc, rp;
	logic [31:0] a, b, xd;
	logic [32:0] qm, rr, rs;
	logic [IW-1:0] r;

	assign z  = in_req.key + lph_pkg::HASH_ADD;
	assign mb = mul_q ? lph_pkg::HASH_MUL2 : lph_pkg::HASH_MUL1;

	// The low 64 bits of a 64x64 product from three 32x32 partial products.
	always_comb begin
		unique case (ph_q)
			2'd0:    begin a = x_q[31:0];  b = mb[31:0];  end
			2'd1:    begin a = x_q[31:0];  b = mb[63:32]; end
			default: begin a = x_q[63:32]; b = mb[31:0];  end
		endcase
		prod = {32'b0, a} * {32'b0, b};
		if (ph_q == 2'd0) begin
			nacc = prod;
		end else begin
			nacc = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
		end
	end

	// The remainder is folded in one 16-bit digit at a time, in two steps. The first
	// step estimates the quotient with a fixed reciprocal; the estimate is at
	// most one short, so the second step needs only one compare and subtract.
	assign xd = 32'({rem_q, h_q[63:48]});
	assign rp = {32'b0, xd} * {32'b0, RCP};
	assign qm = {17'b0, qe_q} * SLOTS_L;
	assign rr = {1'b0, xd} - qm;
	assign rs = rr - SLOTS_L;
	assign r  = (rr >= SLOTS_L) ? rs[IW-1:0] : rr[IW-1:0];

	assign in_ready  = (st_q == F_IDLE);
	assign push      = (st_q == F_PUSH) && !full;
	assign item_req  = req_q;
	assign item_home = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= F_IDLE;
			ph_q  <= 2'd0;
			mul_q <= 1'b0;
			cnt_q <= 3'd0;
		end else begin
			unique case (st_q)
				F_IDLE: begin
					if (in_valid) begin
						st_q  <= F_MUL;
						ph_q  <= 2'd0;
						mul_q <= 1'b0;
					end
				end
				F_MUL: begin
					if (ph_q == 2'd2) begin
						ph_q <= 2'd0;
						if (mul_q) begin
							st_q  <= F_MOD;
							cnt_q <= 3'd0;
						end else begin
							mul_q <= 1'b1;
						end
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				F_MOD: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						st_q <= F_PUSH;
					end
				end
				default: begin
					if (!full) begin
						st_q <= F_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == F_IDLE && in_valid) begin
			req_q <= in_req;
			x_q   <= z ^ (z >> 30);
		end
		if (st_q == F_MUL) begin
			acc_q <= nacc;
			if (ph_q == 2'd2) begin
				if (mul_q) begin
					h_q   <= nacc ^ (nacc >> 31);
					rem_q <= '0;
				end else begin
					x_q <= nacc ^ (nacc >> 27);
				end
			end
		end
		if (st_q == F_MOD) begin
			if (!cnt_q[0]) begin
				qe_q <= rp[47:32];
			end else begin
				rem_q <= r;
				h_q   <= h_q << 16;
			end
		end
	end

endmodule

// ===== rtl/lph_queue.sv =====
// Two-entry queue between the hashing front end and the probe engine.
// Generic width; no package dependencies.
module lph_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);
	logic [WIDTH-1:0] buf_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_data  = buf_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= push_data;
		end
	end

endmodule

// ===== rtl/lph_back.sv =====
// Probe engine: slot memory, linear probe, backward-shift delete, result word.
// Uses lph_pkg; holds the slot store and the occupied count.
module lph_back #(
	parameter int SLOTS      = lph_pkg::SLOTS_DEF,
	parameter int VALUE_BITS = lph_pkg::VALUE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  lph_pkg::req_t            q_req,
	input  logic [$clog2(SLOTS)-1:0] q_home,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output lph_pkg::rsp_t            out_rsp
);
	localparam int IW  = $clog2(SLOTS);
	localparam int CW  = $clog2(SLOTS+1);
	localparam int SVW = (VALUE_BITS < lph_pkg::WORD_BITS) ? VALUE_BITS : lph_pkg::WORD_BITS;
	localparam logic [IW-1:0] SL_MAX  = IW'(SLOTS-1);
	localparam logic [CW-1:0] SL_CNT  = CW'(SLOTS);
	localparam logic [IW:0]   SLOTS_W = (IW+1)'(SLOTS);

	localparam logic [1:0] B_CLR  = 2'd0;
	localparam logic [1:0] B_IDLE = 2'd1;
	localparam logic [1:0] B_FIND = 2'd2;
	localparam logic [1:0] B_DEL  = 2'd3;

	// Slot store: one write and one registered read port.
	logic                mem_valid [SLOTS];
	logic [IW-1:0]       mem_home  [SLOTS];
	logic [63:0]         mem_key   [SLOTS];
	logic [SVW-1:0]      mem_val   [SLOTS];

	logic                we;
	logic [IW-1:0]       wa, ra;
	logic                wd_valid;
	logic [IW-1:0]       wd_home;
	logic [63:0]         wd_key;
	logic [SVW-1:0]      wd_val;

	logic                rm_valid_q, byp_valid_q, byp_q;
	logic [IW-1:0]       rm_home_q, byp_home_q;
	logic [63:0]         rm_key_q, byp_key_q;
	logic [SVW-1:0]      rm_val_q, byp_val_q;

	logic                rv;
	logic [IW-1:0]       rh;
	logic [63:0]         rk;
	logic [SVW-1:0]      rval;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_valid[wa] <= wd_valid;
			mem_home[wa]  <= wd_home;
			mem_key[wa]   <= wd_key;
			mem_val[wa]   <= wd_val;
		end
		rm_valid_q <= mem_valid[ra];
		rm_home_q  <= mem_home[ra];
		rm_key_q   <= mem_key[ra];
		rm_val_q   <= mem_val[ra];
	end

	// A read of the address written in the same cycle returns the new word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= we && (wa == ra);
		end
	end

	always_ff @(posedge clk) begin
		byp_valid_q <= wd_valid;
		byp_home_q  <= wd_home;
		byp_key_q   <= wd_key;
		byp_val_q   <= wd_val;
	end

	assign rv   = byp_q ? byp_valid_q : rm_valid_q;
	assign rh   = byp_q ? byp_home_q  : rm_home_q;
	assign rk   = byp_q ? byp_key_q   : rm_key_q;
	assign rval = byp_q ? byp_val_q   : rm_val_q;

	function automatic logic [IW-1:0] ring_dist(input logic [IW-1:0] from, input logic [IW-1:0] to);
		logic [IW:0] d;
		d = {1'b0, to} - {1'b0, from};
		if (to < from) begin
			d = d + SLOTS_W;
		end
		return d[IW-1:0];
	endfunction

	logic [1:0]          st_q;
	logic [IW-1:0]       clr_q, slot_q, hole_q, home_q, n_q;
	logic [IW:0]         dn_q;
	logic [1:0]          mode_q;
	logic [63:0]         key_q;
	logic [SVW-1:0]      val_q, keep_q;
	logic [CW-1:0]       count_q;
	logic                out_valid_q;
	logic [lph_pkg::STATUS_BITS-1:0] out_status_q;
	logic [SVW-1:0]      out_val_q;
	logic [CW-1:0]       out_count_q;

	logic [IW-1:0]       slot_nx;
	logic                hit, stop_find, stop_del, move;
	logic                emit;
	logic [lph_pkg::STATUS_BITS-1:0] emit_status;
	logic [SVW-1:0]      emit_val;
	logic [CW-1:0]       count_nx;
	logic [CW+lph_pkg::COUNT_BITS-1:0] count_ext;
	logic [lph_pkg::WORD_BITS:0]       val_ext;

	assign slot_nx   = (slot_q == SL_MAX) ? '0 : slot_q + 1'b1;
	assign hit       = rv && (rk == key_q);
	assign stop_find = !rv || (n_q == SL_MAX);
	assign stop_del  = !rv || (slot_q == hole_q) || (dn_q == SLOTS_W);
	assign move      = ring_dist(rh, hole_q) < ring_dist(rh, slot_q);
	assign pop       = (st_q == B_IDLE) && q_valid && !out_valid_q;

	always_comb begin
		we          = 1'b0;
		wa          = slot_q;
		wd_valid    = 1'b1;
		wd_home     = home_q;
		wd_key      = key_q;
		wd_val      = val_q;
		ra          = slot_q;
		emit        = 1'b0;
		emit_status = lph_pkg::ST_MISS;
		emit_val    = '0;
		count_nx    = count_q;
		unique case (st_q)
			B_CLR: begin
				we       = 1'b1;
				wa       = clr_q;
				wd_valid = 1'b0;
			end
			B_IDLE: begin
				ra = q_home;
				if (pop && q_req.mode == lph_pkg::MODE_UNUSED) begin
					emit = 1'b1;
				end
			end
			B_FIND: begin
				ra = slot_nx;
				if (hit) begin
					priority case (mode_q)
						lph_pkg::MODE_INSERT: begin
							we          = 1'b1;
							wd_home     = rh;
							emit        = 1'b1;
							emit_status = lph_pkg::ST_UPDATED;
						end
						lph_pkg::MODE_LOOKUP: begin
							emit        = 1'b1;
							emit_status = lph_pkg::ST_HIT;
							emit_val    = rval;
						end
						default: begin
						end
					endcase
				end else if (stop_find) begin
					emit = 1'b1;
					if (mode_q == lph_pkg::MODE_INSERT) begin
						if (count_q == SL_CNT) begin
							emit_status = lph_pkg::ST_FULL;
						end else begin
							we          = 1'b1;
							emit_status = lph_pkg::ST_NEW;
							count_nx    = count_q + 1'b1;
						end
					end
				end
			end
			default: begin
				ra = slot_nx;
				wa = hole_q;
				if (stop_del) begin
					we          = 1'b1;
					wd_valid    = 1'b0;
					emit        = 1'b1;
					emit_status = lph_pkg::ST_HIT;
					emit_val    = keep_q;
					count_nx    = count_q - 1'b1;
				end else if (move) begin
					we      = 1'b1;
					wd_home = rh;
					wd_key  = rk;
					wd_val  = rval;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_CLR;
			clr_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nx;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SL_MAX) begin
						st_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop && q_req.mode != lph_pkg::MODE_UNUSED) begin
						st_q <= B_FIND;
					end
				end
				B_FIND: begin
					if (hit && mode_q == lph_pkg::MODE_REMOVE) begin
						st_q <= B_DEL;
					end else if (hit || stop_find) begin
						st_q <= B_IDLE;
					end
				end
				default: begin
					if (stop_del) begin
						st_q <= B_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mode_q <= q_req.mode;
			key_q  <= q_req.key;
			val_q  <= q_req.value[SVW-1:0];
			home_q <= q_home;
			slot_q <= q_home;
			n_q    <= '0;
		end
		if (st_q == B_FIND) begin
			slot_q <= slot_nx;
			n_q    <= n_q + 1'b1;
			if (hit) begin
				hole_q <= slot_q;
				keep_q <= rval;
				dn_q   <= (IW+1)'(1);
			end
		end
		if (st_q == B_DEL) begin
			slot_q <= slot_nx;
			dn_q   <= dn_q + 1'b1;
			if (!stop_del && move) begin
				hole_q <= slot_q;
			end
		end
		if (emit) begin
			out_status_q <= emit_status;
			out_val_q    <= emit_val;
			out_count_q  <= count_nx;
		end
	end

	assign count_ext      = {{lph_pkg::COUNT_BITS{1'b0}}, out_count_q};
	assign val_ext        = {{(lph_pkg::WORD_BITS-SVW+1){1'b0}}, out_val_q};
	assign out_valid      = out_valid_q;
	assign out_rsp.status = out_status_q;
	assign out_rsp.value  = val_ext[lph_pkg::WORD_BITS-1:0];
	assign out_rsp.count  = count_ext[lph_pkg::COUNT_BITS-1:0];

endmodule

// ===== rtl/linear_probe_hash_map.sv =====
// Top level of the linear-probing hash map: front end, queue, probe engine.
// Uses lph_pkg, lph_front, lph_queue and lph_back.
//
//  Port group   Direction  Word contents (low bit first)
//  s_*          in         mode[1:0], key[65:2], value_in[97:66], zero fill
//  m_*          out        status[2:0], value_out[34:3], entry_count[45:35], zero fill
//
// The front end hashes one key at a time (six multiplier passes, the remainder
// folding, one push); it overlaps the probe of the previous request.
// The probe engine also takes one request at a time: it probes slot by slot
// from the home slot, then on a remove walks the backward shift.
// After reset a clearing pass over every slot empties the slot store before the
// first probe; requests are queued meanwhile. A stalled output holds its word.
module linear_probe_hash_map #(
	parameter int SLOTS      = lph_pkg::SLOTS_DEF,
	parameter int VALUE_BITS = lph_pkg::VALUE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,   // mode, key, value_in
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata    // status, value_out, entry_count
);
	localparam int IW = $clog2(SLOTS);
	localparam int QW = $bits(lph_pkg::req_t) + IW;

	lph_pkg::req_t in_req, f_req, b_req;
	lph_pkg::rsp_t rsp;
	logic [IW-1:0] f_home, b_home;
	logic          push, full, pop, not_empty;
	logic [QW-1:0] q_out;

	assign in_req.mode  = s_tdata[1:0];
	assign in_req.key   = s_tdata[65:2];
	assign in_req.value = s_tdata[97:66];

	lph_front #(.SLOTS(SLOTS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (in_req),
		.push      (push),
		.full      (full),
		.item_req  (f_req),
		.item_home (f_home)
	);

	lph_queue #(.WIDTH(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({f_req, f_home}),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (q_out)
	);

	assign b_req  = q_out[QW-1:IW];
	assign b_home = q_out[IW-1:0];

	lph_back #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (not_empty),
		.q_req     (b_req),
		.q_home    (b_home),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rsp   (rsp)
	);

	assign m_tdata = {2'b00, rsp.count, rsp.value, rsp.status};

endmodule

// ===== rtl/lph_checker.sv =====
// Port-level checks for the hash map, attached to the top level by bind.
// Uses lph_pkg for the status codes.
module lph_checker #(
	parameter int SLOTS = lph_pkg::SLOTS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [103:0] s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [47:0]  m_tdata
);
	localparam logic [11:0] MAX_CNT = 12'(SLOTS);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word dropped or changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= lph_pkg::ST_FULL)
		else $error("status code out of range");

	a_zero_val: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != lph_pkg::ST_HIT |-> m_tdata[34:3] == 32'd0)
		else $error("value word not zero on a result without data");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == lph_pkg::ST_NEW |-> {1'b0, m_tdata[45:35]} != 12'd0
		&& ({1'b0, m_tdata[45:35]} <= MAX_CNT || SLOTS > 2047))
		else $error("entry count inconsistent with an insert");

endmodule

bind linear_probe_hash_map lph_checker #(.SLOTS(SLOTS)) u_lph_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the linear-probing hash map.
// Drives insert, remove and lookup requests and compares every result against
// an in-bench model of the table; depends on lph_pkg and linear_probe_hash_map.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOTS = 1024;
	localparam int RANDOM_ITEMS = 530;
	localparam longint CYCLE_LIMIT = 5000000;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] value;
		logic [10:0] count;
	} result_t;

	typedef struct {
		logic [1:0]  mode;
		logic [63:0] key;
		logic [31:0] value;
		bit          typed;
		result_t     want;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [103:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [47:0]  m_tdata;

	linear_probe_hash_map DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #1 clk = ~clk;

	// Model of the table.
	logic [63:0] tbl_key[NSLOTS];
	logic [31:0] tbl_val[NSLOTS];
	bit          tbl_used[NSLOTS];
	int          tbl_count;

	result_t     pending_results[$];
	int          mismatches = 0;
	bit          failed = 0;
	longint      cycles = 0;
	int          stall_left = 0;

	// Key pool so that removes and lookups often hit.
	logic [63:0] known_keys[$];

	function automatic int home_slot(input logic [63:0] k);
		logic [63:0] z;
		z = k + lph_pkg::HASH_ADD;
		z = (z ^ (z >> 30)) * lph_pkg::HASH_MUL1;
		z = (z ^ (z >> 27)) * lph_pkg::HASH_MUL2;
		z = z ^ (z >> 31);
		return int'(z % NSLOTS);
	endfunction

	function automatic int locate(input logic [63:0] k);
		int s;
		s = home_slot(k);
		for (int n = 0; n < NSLOTS; n++) begin
			if (!tbl_used[s])
				return -1;
			if (tbl_key[s] == k)
				return s;
			s = (s + 1) % NSLOTS;
		end
		return -1;
	endfunction

	// Backward-shift deletion keeps every probe run free of holes.
	function automatic void erase_slot(input int hole);
		int j;
		int h;
		j = hole;
		for (int n = 1; n < NSLOTS; n++) begin
			j = (j + 1) % NSLOTS;
			if (!tbl_used[j] || j == hole)
				break;
			h = home_slot(tbl_key[j]);
			if ((hole - h + NSLOTS) % NSLOTS < (j - h + NSLOTS) % NSLOTS) begin
				tbl_key[hole] = tbl_key[j];
				tbl_val[hole] = tbl_val[j];
				hole = j;
			end
		end
		tbl_used[hole] = 0;
	endfunction

	function automatic result_t apply_request(input logic [1:0] mode, input logic [63:0] k,
			input logic [31:0] v);
		result_t r;
		int s;
		r.status = lph_pkg::ST_MISS;
		r.value = '0;
		s = locate(k);
		case (mode)
			lph_pkg::MODE_INSERT: begin
				if (s >= 0) begin
					tbl_val[s] = v;
					r.status = lph_pkg::ST_UPDATED;
				end else if (tbl_count >= NSLOTS) begin
					r.status = lph_pkg::ST_FULL;
				end else begin
					s = home_slot(k);
					while (tbl_used[s])
						s = (s + 1) % NSLOTS;
					tbl_key[s] = k;
					tbl_val[s] = v;
					tbl_used[s] = 1;
					tbl_count++;
					r.status = lph_pkg::ST_NEW;
				end
			end
			lph_pkg::MODE_REMOVE: begin
				if (s >= 0) begin
					r.value = tbl_val[s];
					erase_slot(s);
					tbl_count--;
					r.status = lph_pkg::ST_HIT;
				end
			end
			lph_pkg::MODE_LOOKUP: begin
				if (s >= 0) begin
					r.value = tbl_val[s];
					r.status = lph_pkg::ST_HIT;
				end
			end
			default: ;
		endcase
		r.count = 11'(tbl_count);
		return r;
	endfunction

	task automatic send_request(input logic [1:0] mode, input logic [63:0] k,
			input logic [31:0] v, input bit typed, input result_t want);
		result_t r;
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, v, k, mode};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = apply_request(mode, k, v);
		if (typed && r != want) begin
			failed = 1;
			$display("directed row disagrees with model: key %h typed %h model %h", k, want, r);
		end
		pending_results.push_back(r);
	endtask

	// Result side: random stalls, checks each word against the oldest expectation.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[2:0];
				got.value = m_tdata[34:3];
				got.count = m_tdata[45:35];
				if (pending_results.size() == 0) begin
					failed = 1;
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %h", got);
				end else begin
					want = pending_results.pop_front();
					if (got != want) begin
						failed = 1;
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: status %0d/%0d value %h/%h count %0d/%0d",
								want.status, got.status, want.value, got.value,
								want.count, got.count);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 19) == 0) begin
				stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
					: $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	row_t rows[$];

	function automatic row_t mk(input logic [1:0] m, input logic [63:0] k, input logic [31:0] v,
			input bit typed = 0, input logic [2:0] st = 0, input logic [31:0] vo = 0,
			input logic [10:0] c = 0);
		row_t r;
		r.mode = m; r.key = k; r.value = v; r.typed = typed;
		r.want = '{st, vo, c};
		return r;
	endfunction

	initial begin
		logic [1:0]  mode;
		logic [63:0] k;
		logic [31:0] v;
		int          pick;
		for (int i = 0; i < NSLOTS; i++)
			tbl_used[i] = 0;
		tbl_count = 0;

		// Directed table: extremes, every mode, absent keys, the unused mode.
		rows.push_back(mk(lph_pkg::MODE_LOOKUP, 64'h0, 32'h0, 1, lph_pkg::ST_MISS, 0, 0));
		rows.push_back(mk(lph_pkg::MODE_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1,
			lph_pkg::ST_MISS, 0, 0));
		rows.push_back(mk(lph_pkg::MODE_INSERT, 64'h0, 32'hFFFF_FFFF, 1, lph_pkg::ST_NEW, 0, 1));
		rows.push_back(mk(lph_pkg::MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1,
			lph_pkg::ST_NEW, 0, 2));
		rows.push_back(mk(lph_pkg::MODE_LOOKUP, 64'h0, 32'h1234, 1, lph_pkg::ST_HIT,
			32'hFFFF_FFFF, 2));
		rows.push_back(mk(lph_pkg::MODE_INSERT, 64'h0, 32'hA5A5_5A5A, 1,
			lph_pkg::ST_UPDATED, 0, 2));
		rows.push_back(mk(lph_pkg::MODE_UNUSED, 64'h0, 32'hFFFF_FFFF, 1, lph_pkg::ST_MISS, 0, 2));
		rows.push_back(mk(lph_pkg::MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1,
			lph_pkg::ST_HIT, 0, 2));
		rows.push_back(mk(lph_pkg::MODE_REMOVE, 64'h0, 32'h0, 1, lph_pkg::ST_HIT,
			32'hA5A5_5A5A, 1));
		rows.push_back(mk(lph_pkg::MODE_LOOKUP, 64'h0, 32'h0, 1, lph_pkg::ST_MISS, 0, 1));
		rows.push_back(mk(lph_pkg::MODE_INSERT, 64'h8000_0000_0000_0001, 32'h8000_0001));
		rows.push_back(mk(lph_pkg::MODE_INSERT, 64'h5555_5555_5555_5555, 32'h5555_5555));
		rows.push_back(mk(lph_pkg::MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA));
		rows.push_back(mk(lph_pkg::MODE_REMOVE, 64'h5555_5555_5555_5555, 32'h0));
		rows.push_back(mk(lph_pkg::MODE_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0));
		rows.push_back(mk(lph_pkg::MODE_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0));
		rows.push_back(mk(lph_pkg::MODE_UNUSED, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_request(rows[i].mode, rows[i].key, rows[i].value, rows[i].typed, rows[i].want);

		// The sender holds off until every result has come back.
		wait_drained();

		// Random part: keys from a small pool so probes collide, clusters form
		// and removes shift entries back.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) mode = lph_pkg::MODE_INSERT;
			else if (pick < 75) mode = lph_pkg::MODE_REMOVE;
			else if (pick < 97) mode = lph_pkg::MODE_LOOKUP;
			else mode = lph_pkg::MODE_UNUSED;
			if (known_keys.size() > 0 && $urandom_range(0, 2) != 0)
				k = known_keys[$urandom_range(0, known_keys.size() - 1)];
			else begin
				k = {$urandom, $urandom};
				if (mode == lph_pkg::MODE_INSERT)
					known_keys.push_back(k);
			end
			v = $urandom;
			send_request(mode, k, v, 0, '0);
		end

		wait_drained();
		repeat (2000) @(posedge clk);
		if (!failed && pending_results.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
